FILE: rtl/i2cnsp_pkg.sv
package i2cnsp_pkg;

    // Operation codes of an input item.
    localparam logic [2:0] OP_BEGIN = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_STOP  = 3'd4;
    localparam logic [2:0] OP_END   = 3'd5;

    // Sequencer command nibbles.
    localparam logic [3:0] CMD_ZERO  = 4'h0;
    localparam logic [3:0] CMD_2     = 4'h2;
    localparam logic [3:0] CMD_3     = 4'h3;
    localparam logic [3:0] CMD_4     = 4'h4;
    localparam logic [3:0] CMD_5     = 4'h5;
    localparam logic [3:0] CMD_BIT0  = 4'h8;
    localparam logic [3:0] CMD_BIT1  = 4'hc;
    localparam logic [3:0] CMD_RDBIT = 4'hd;
    localparam logic [3:0] CMD_WACK  = 4'he;

    // Command counts of the fixed expansions.
    localparam logic [3:0] CNT_START = 4'd4;
    localparam logic [3:0] CNT_STOP  = 4'd3;
    localparam logic [3:0] CNT_BYTE  = 4'd9;

    // Most commands one item expands into.
    localparam int NIB_SLOTS = 9;

    // Classified item as it travels from the front to the back.
    typedef struct packed {
        logic                      is_begin;
        logic                      is_end;
        logic [3:0]                cnt;
        logic [4*NIB_SLOTS-1:0]    nibs;
    } cmd_t;

endpackage

FILE: rtl/i2cnsp_fifo.sv
module i2cnsp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    // Writes are dropped when full; reads are ignored when empty.
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage entries carry no reset.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: rtl/i2cnsp_front.sv
module i2cnsp_front (
    input  logic               push,
    input  logic [2:0]         op,
    input  logic [7:0]         data_byte,
    input  logic               last_read,
    input  logic               q_full,
    output logic               full,
    output logic               q_wr,
    output i2cnsp_pkg::cmd_t   q_data
);

    logic keep;

    // Expand the operation into its command list. Unused codes are dropped.
    always_comb
    begin
        q_data = '0;
        keep   = 1'b1;
        unique case (op)
            i2cnsp_pkg::OP_BEGIN:
            begin
                q_data.is_begin = 1'b1;
            end
            i2cnsp_pkg::OP_START:
            begin
                q_data.cnt          = i2cnsp_pkg::CNT_START;
                q_data.nibs[3:0]    = i2cnsp_pkg::CMD_5;
                q_data.nibs[7:4]    = i2cnsp_pkg::CMD_3;
                q_data.nibs[11:8]   = i2cnsp_pkg::CMD_4;
                q_data.nibs[15:12]  = i2cnsp_pkg::CMD_2;
            end
            i2cnsp_pkg::OP_WRITE:
            begin
                q_data.cnt = i2cnsp_pkg::CNT_BYTE;
                for (int k = 0; k < 8; k++)
                begin
                    q_data.nibs[4*k +: 4] = data_byte[7-k] ? i2cnsp_pkg::CMD_BIT1
                                                           : i2cnsp_pkg::CMD_BIT0;
                end
                q_data.nibs[35:32] = i2cnsp_pkg::CMD_WACK;
            end
            i2cnsp_pkg::OP_READ:
            begin
                q_data.cnt = i2cnsp_pkg::CNT_BYTE;
                for (int k = 0; k < 8; k++)
                begin
                    q_data.nibs[4*k +: 4] = i2cnsp_pkg::CMD_RDBIT;
                end
                q_data.nibs[35:32] = last_read ? i2cnsp_pkg::CMD_BIT1 : i2cnsp_pkg::CMD_BIT0;
            end
            i2cnsp_pkg::OP_STOP:
            begin
                q_data.cnt        = i2cnsp_pkg::CNT_STOP;
                q_data.nibs[3:0]  = i2cnsp_pkg::CMD_4;
                q_data.nibs[7:4]  = i2cnsp_pkg::CMD_3;
                q_data.nibs[11:8] = i2cnsp_pkg::CMD_5;
            end
            i2cnsp_pkg::OP_END:
            begin
                // The back decides between one and two zero commands.
                q_data.is_end = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // The input side is full exactly when the command queue is.
    assign full = q_full;
    assign q_wr = push && !q_full && keep;

endmodule

FILE: rtl/i2cnsp_back.sv
module i2cnsp_back #(
    parameter int ADDR_WIDTH = 11
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  i2cnsp_pkg::cmd_t      cmd,
    input  logic                  cmd_valid,
    output logic                  cmd_pop,
    input  logic                  out_full,
    output logic                  out_wr,
    output logic [7:0]            out_byte,
    output logic [ADDR_WIDTH-1:0] out_addr,
    output logic                  out_last
);

    logic [3:0]            pos_reg;
    logic [3:0]            pos_next;
    logic [3:0]            pend_reg;
    logic [3:0]            pend_next;
    logic                  half_reg;
    logic                  half_next;
    logic [ADDR_WIDTH-1:0] addr_reg;
    logic [ADDR_WIDTH-1:0] addr_next;

    logic [3:0]                         cnt_eff;
    logic [3:0]                         rem;
    logic [4*i2cnsp_pkg::NIB_SLOTS-1:0] shifted;
    logic [3:0]                         nib0;
    logic [3:0]                         nib1;
    logic [3:0]                         nib2;

    // An end item needs one zero command to close a half byte, else two.
    assign cnt_eff = cmd.is_end ? (half_reg ? 4'd1 : 4'd2) : cmd.cnt;
    assign rem     = cnt_eff - pos_reg;
    assign shifted = cmd.nibs >> {pos_reg, 2'b00};
    assign nib0    = shifted[3:0];
    assign nib1    = shifted[7:4];
    assign nib2    = shifted[11:8];
    assign out_addr = addr_reg;

    // Up to a byte per cycle, none on out_full; a lone command parks as pending.
    always_comb
    begin
        logic [3:0] use_cnt;
        logic [3:0] left;
        logic [3:0] stash;
        use_cnt   = '0;
        left      = '0;
        stash     = '0;
        pos_next  = pos_reg;
        pend_next = pend_reg;
        half_next = half_reg;
        addr_next = addr_reg;
        cmd_pop   = 1'b0;
        out_wr    = 1'b0;
        out_byte  = {nib1, nib0};
        out_last  = 1'b0;
        if (cmd_valid && !out_full)
        begin
            if (cmd.is_begin)
            begin
                addr_next = '0;
                cmd_pop   = 1'b1;
            end
            else if ((half_reg && rem != 4'd0) || (!half_reg && rem >= 4'd2))
            begin
                out_wr = 1'b1;
                if (half_reg)
                begin
                    out_byte = {nib0, pend_reg};
                    use_cnt  = 4'd1;
                    stash    = nib1;
                end
                else
                begin
                    out_byte = {nib1, nib0};
                    use_cnt  = 4'd2;
                    stash    = nib2;
                end
                addr_next = addr_reg + 1'b1;
                left      = rem - use_cnt;
                if (left == 4'd1)
                begin
                    pend_next = stash;
                    half_next = 1'b1;
                    pos_next  = '0;
                    cmd_pop   = 1'b1;
                    out_last  = 1'b1;
                end
                else if (left == 4'd0)
                begin
                    half_next = 1'b0;
                    pos_next  = '0;
                    cmd_pop   = 1'b1;
                    out_last  = 1'b1;
                end
                else
                begin
                    half_next = 1'b0;
                    pos_next  = pos_reg + use_cnt;
                end
            end
            else
            begin
                // At most one command left and no partner: park it, no byte.
                if (rem == 4'd1)
                begin
                    pend_next = nib0;
                    half_next = 1'b1;
                end
                pos_next = '0;
                cmd_pop  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            pend_reg <= '0;
            half_reg <= 1'b0;
            addr_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            pend_reg <= pend_next;
            half_reg <= half_next;
            addr_reg <= addr_next;
        end
    end

endmodule

FILE: rtl/i2c_nibble_sequence_packer.sv
// I2C command packer. Each accepted item (begin, start, write byte, read byte,
// stop, end) is expanded into 4-bit sequencer commands that are packed two per
// result byte, first command in the low nibble, each result carrying the
// command memory address it belongs at; last marks the final result of an item.
// The input side takes one item per cycle, unless the two-entry command queue
// is full, while the packing sequencer drains that queue, emitting at most one
// byte per cycle into a two-entry result queue and none while it is full. An
// item yields as many bytes as its commands fill: start 2, stop 1 or 2, write
// and read byte 4 or 5 (9 commands plus a possibly pending one), end 1 and
// begin none, so a stream of byte transfers is bounded by the sequencer's
// single byte per cycle. Unused op codes are taken and dropped.
module i2c_nibble_sequence_packer #(
    parameter int ADDR_WIDTH = 11
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [2:0]            op,
    input  logic [7:0]            data_byte,
    input  logic                  last_read,
    output logic                  empty,
    input  logic                  pop,
    output logic [7:0]            mem_byte,
    output logic [ADDR_WIDTH-1:0] mem_addr,
    output logic                  last
);

    localparam int CMD_W = $bits(i2cnsp_pkg::cmd_t);
    localparam int RES_W = 8 + ADDR_WIDTH + 1;

    i2cnsp_pkg::cmd_t      fq_wr_data;
    i2cnsp_pkg::cmd_t      fq_rd_data;
    logic [CMD_W-1:0]      fq_rd_bits;
    logic                  fq_wr;
    logic                  fq_full;
    logic                  fq_empty;
    logic                  fq_pop;

    logic                  rq_wr;
    logic                  rq_full;
    logic [7:0]            rq_byte;
    logic [ADDR_WIDTH-1:0] rq_addr;
    logic                  rq_last;
    logic [RES_W-1:0]      rq_rd_data;

    // Front: classify and expand items.
    i2cnsp_front u_front (
        .push      (push),
        .op        (op),
        .data_byte (data_byte),
        .last_read (last_read),
        .q_full    (fq_full),
        .full      (full),
        .q_wr      (fq_wr),
        .q_data    (fq_wr_data)
    );

    // Command queue between front and back.
    i2cnsp_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (fq_wr),
        .wr_data (fq_wr_data),
        .rd      (fq_pop),
        .rd_data (fq_rd_bits),
        .full    (fq_full),
        .empty   (fq_empty)
    );

    assign fq_rd_data = i2cnsp_pkg::cmd_t'(fq_rd_bits);

    // Back: nibble packing sequencer.
    i2cnsp_back #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (fq_rd_data),
        .cmd_valid (!fq_empty),
        .cmd_pop   (fq_pop),
        .out_full  (rq_full),
        .out_wr    (rq_wr),
        .out_byte  (rq_byte),
        .out_addr  (rq_addr),
        .out_last  (rq_last)
    );

    // Result queue toward the consumer.
    i2cnsp_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (rq_wr),
        .wr_data ({rq_last, rq_addr, rq_byte}),
        .rd      (pop),
        .rd_data (rq_rd_data),
        .full    (rq_full),
        .empty   (empty)
    );

    assign mem_byte = rq_rd_data[7:0];
    assign mem_addr = rq_rd_data[8 +: ADDR_WIDTH];
    assign last     = rq_rd_data[RES_W-1];

endmodule

FILE: rtl/i2cnsp_checker.sv
module i2cnsp_checker #(
    parameter int ADDR_WIDTH = 11
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  full,
    input logic                  empty,
    input logic                  pop,
    input logic [7:0]            mem_byte,
    input logic [ADDR_WIDTH-1:0] mem_addr,
    input logic                  last
);

    logic                  open_reg;
    logic [ADDR_WIDTH-1:0] prev_addr_reg;

    // Track whether the previous taken result left its item unfinished.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
        end
        else if (pop && !empty)
        begin
            open_reg <= !last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && !empty)
        begin
            prev_addr_reg <= mem_addr;
        end
    end

    // A waiting result stays put until taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(mem_byte) && $stable(mem_addr)
                              && $stable(last)))
        else $error("waiting result changed before it was taken");

    // Both sides come out of reset idle.
    a_reset_idle: assert property (@(posedge clk)
        $rose(rst_n) |-> (empty && !full))
        else $error("block not idle after reset");

    // Results inside an item never come from end, so both commands are nonzero.
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !last) |-> (mem_byte[7:4] != 4'h0 && mem_byte[3:0] != 4'h0))
        else $error("zero command inside an item");

    // Results of one item go to consecutive addresses.
    a_addr_step: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && open_reg) |-> (mem_addr == ADDR_WIDTH'(prev_addr_reg + 1'b1)))
        else $error("address skipped within an item");

endmodule

bind i2c_nibble_sequence_packer i2cnsp_checker #(.ADDR_WIDTH(ADDR_WIDTH)) u_checker (.*);

FILE: dv/i2c_nibble_sequence_packer_tb.sv
`timescale 1ns / 1ps

module i2c_nibble_sequence_packer_tb;

    localparam int AW = 11;

    // Op codes the block takes and drops.
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 40;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data_byte;
        logic       last_read;
    } op_item_t;

    typedef struct packed {
        logic [7:0]    mem_byte;
        logic [AW-1:0] mem_addr;
        logic          last;
    } mem_write_t;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          push      = 1'b0;
    logic [2:0]    op        = i2cnsp_pkg::OP_BEGIN;
    logic [7:0]    data_byte = 8'h00;
    logic          last_read = 1'b0;
    logic          pop       = 1'b0;
    logic          full;
    logic          empty;
    logic [7:0]    mem_byte;
    logic [AW-1:0] mem_addr;
    logic          last;

    // Items waiting to be offered, and command memory writes still to come.
    op_item_t   pending_ops[$];
    mem_write_t expected_writes[$];

    // Copy of the packer state, reset to zero.
    logic [3:0]    held_nib   = 4'h0;
    logic          held_valid = 1'b0;
    logic [AW-1:0] next_addr  = '0;

    // Handshake and flow control between the processes.
    logic     item_taken    = 1'b0;
    logic     hold_req      = 1'b0;
    int       hold_left     = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       stall_cycles  = 0;
    logic     moved;
    op_item_t tx_item;
    op_item_t rx_item;

    // Run statistics.
    int items_queued   = 0;
    int items_accepted = 0;
    int writes_checked = 0;
    int addr_wraps     = 0;
    int mismatches     = 0;

    i2c_nibble_sequence_packer #(
        .ADDR_WIDTH(AW)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .op        (op),
        .data_byte (data_byte),
        .last_read (last_read),
        .empty     (empty),
        .pop       (pop),
        .mem_byte  (mem_byte),
        .mem_addr  (mem_addr),
        .last      (last)
    );

    always #2 clk = ~clk;

    // Pairs commands into bytes: the first of a pair lands in the low nibble.
    task pack_nibble(input logic [3:0] cmd);
        mem_write_t w;
        if (held_valid)
        begin
            w.mem_byte = {cmd, held_nib};
            w.mem_addr = next_addr;
            w.last     = 1'b0;
            expected_writes.push_back(w);
            next_addr  = next_addr + 1'b1;
            if (next_addr == '0)
                addr_wraps++;
            held_valid = 1'b0;
        end
        else
        begin
            held_nib   = cmd;
            held_valid = 1'b1;
        end
    endtask

    // Expands one accepted item into commands and marks its final byte.
    task pack_op(input op_item_t it);
        int         first_cnt;
        mem_write_t w;
        first_cnt = expected_writes.size();
        case (it.op)
            i2cnsp_pkg::OP_BEGIN:
                next_addr = '0;
            i2cnsp_pkg::OP_START:
            begin
                pack_nibble(i2cnsp_pkg::CMD_5);
                pack_nibble(i2cnsp_pkg::CMD_3);
                pack_nibble(i2cnsp_pkg::CMD_4);
                pack_nibble(i2cnsp_pkg::CMD_2);
            end
            i2cnsp_pkg::OP_WRITE:
            begin
                for (int i = 7; i >= 0; i--)
                    pack_nibble(it.data_byte[i] ? i2cnsp_pkg::CMD_BIT1 : i2cnsp_pkg::CMD_BIT0);
                pack_nibble(i2cnsp_pkg::CMD_WACK);
            end
            i2cnsp_pkg::OP_READ:
            begin
                repeat (8)
                    pack_nibble(i2cnsp_pkg::CMD_RDBIT);
                pack_nibble(it.last_read ? i2cnsp_pkg::CMD_BIT1 : i2cnsp_pkg::CMD_BIT0);
            end
            i2cnsp_pkg::OP_STOP:
            begin
                pack_nibble(i2cnsp_pkg::CMD_4);
                pack_nibble(i2cnsp_pkg::CMD_3);
                pack_nibble(i2cnsp_pkg::CMD_5);
            end
            i2cnsp_pkg::OP_END:
            begin
                pack_nibble(i2cnsp_pkg::CMD_ZERO);
                if (held_valid)
                    pack_nibble(i2cnsp_pkg::CMD_ZERO);
            end
            default:
                ;
        endcase
        if (expected_writes.size() > first_cnt)
        begin
            w      = expected_writes.pop_back();
            w.last = 1'b1;
            expected_writes.push_back(w);
        end
    endtask

    task flag_error(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    // Compares the byte on the result ports with the oldest expected write.
    task check_write;
        mem_write_t w;
        if (expected_writes.size() == 0)
        begin
            flag_error($sformatf("unexpected byte %02h at addr %0d last %0b",
                                 mem_byte, mem_addr, last));
        end
        else
        begin
            w = expected_writes.pop_front();
            writes_checked++;
            if (mem_byte !== w.mem_byte || mem_addr !== w.mem_addr || last !== w.last)
                flag_error($sformatf("expected byte %02h addr %0d last %0b, got %02h %0d %0b",
                                     w.mem_byte, w.mem_addr, w.last,
                                     mem_byte, mem_addr, last));
        end
    endtask

    task queue_op(input logic [2:0] code, input logic [7:0] d, input logic lr);
        op_item_t it;
        it.op        = code;
        it.data_byte = d;
        it.last_read = lr;
        pending_ops.push_back(it);
        if (code != OP_RSVD6 && code != OP_RSVD7)
            items_queued++;
    endtask

    // Queues an op with random data and read flag.
    task queue_rand(input logic [2:0] code);
        queue_op(code, 8'($urandom), 1'($urandom));
    endtask

    // Extremes of the fields, every op, begin and end with a half-filled byte.
    task queue_directed;
        queue_op(i2cnsp_pkg::OP_BEGIN, 8'h00, 1'b0);
        queue_op(i2cnsp_pkg::OP_START, 8'hff, 1'b1);
        queue_op(i2cnsp_pkg::OP_WRITE, 8'h00, 1'b0);
        queue_op(i2cnsp_pkg::OP_WRITE, 8'hff, 1'b1);
        queue_op(i2cnsp_pkg::OP_END, 8'h00, 1'b0);
        queue_op(i2cnsp_pkg::OP_STOP, 8'h00, 1'b0);
        queue_op(i2cnsp_pkg::OP_END, 8'hff, 1'b1);
        queue_op(i2cnsp_pkg::OP_START, 8'h00, 1'b0);
        queue_op(i2cnsp_pkg::OP_WRITE, 8'ha5, 1'b0);
        queue_op(i2cnsp_pkg::OP_BEGIN, 8'hff, 1'b1);
        queue_op(i2cnsp_pkg::OP_READ, 8'h00, 1'b0);
        queue_op(i2cnsp_pkg::OP_READ, 8'hff, 1'b1);
        queue_op(OP_RSVD6, 8'hff, 1'b1);
        queue_op(OP_RSVD7, 8'h00, 1'b0);
        queue_op(i2cnsp_pkg::OP_STOP, 8'hff, 1'b1);
        queue_op(i2cnsp_pkg::OP_END, 8'h00, 1'b0);
        queue_op(i2cnsp_pkg::OP_WRITE, 8'h5a, 1'b1);
        queue_op(i2cnsp_pkg::OP_STOP, 8'h00, 1'b0);
        queue_op(i2cnsp_pkg::OP_END, 8'h00, 1'b0);
        queue_op(i2cnsp_pkg::OP_BEGIN, 8'h00, 1'b0);
        queue_op(i2cnsp_pkg::OP_READ, 8'hff, 1'b1);
        queue_op(i2cnsp_pkg::OP_END, 8'h00, 1'b1);
    endtask

    // A well-formed transfer: maybe begin, then start, address and data writes, an
    // optional repeated start with an address write and reads, then stop and maybe end.
    task queue_transfer;
        int n_wr;
        int n_rd;
        if ($urandom_range(3) == 0)
            queue_rand(i2cnsp_pkg::OP_BEGIN);
        queue_rand(i2cnsp_pkg::OP_START);
        queue_rand(i2cnsp_pkg::OP_WRITE);
        n_wr = $urandom_range(3);
        repeat (n_wr)
            queue_rand(i2cnsp_pkg::OP_WRITE);
        if ($urandom_range(1) == 1)
        begin
            queue_rand(i2cnsp_pkg::OP_START);
            queue_rand(i2cnsp_pkg::OP_WRITE);
            n_rd = $urandom_range(1, 3);
            for (int i = 1; i <= n_rd; i++)
                queue_op(i2cnsp_pkg::OP_READ, 8'($urandom), i == n_rd);
        end
        queue_rand(i2cnsp_pkg::OP_STOP);
        if ($urandom_range(1) == 1)
            queue_rand(i2cnsp_pkg::OP_END);
    endtask

    // Mostly transfers, the rest short runs of arbitrary ops.
    task queue_random(input int count);
        int target;
        target = items_queued + count;
        while (items_queued < target)
        begin
            if ($urandom_range(99) < 80)
                queue_transfer();
            else
                repeat ($urandom_range(1, 3))
                    queue_rand(3'($urandom_range(OP_RSVD7)));
        end
    endtask

    task wait_drained;
        while (pending_ops.size() != 0 || push || expected_writes.size() != 0)
            @(posedge clk);
    endtask

    // Sender: offers the next item once the current one is taken.
    always @(negedge clk)
    begin
        if (rst_n && (!push || item_taken))
        begin
            item_taken = 1'b0;
            if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                tx_item = pending_ops.pop_front();
                push      <= 1'b1;
                op        <= tx_item.op;
                data_byte <= tx_item.data_byte;
                last_read <= tx_item.last_read;
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // Receiver: random pops, with one long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
        begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Both handshakes are sampled here; the watchdog counts idle edges.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            moved = 1'b0;
            if (pop && !empty)
            begin
                check_write();
                moved = 1'b1;
            end
            if (push && !full)
            begin
                rx_item = {op, data_byte, last_read};
                pack_op(rx_item);
                item_taken = 1'b1;
                items_accepted++;
                moved = 1'b1;
            end
            if (moved)
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT)
                begin
                    $display("ERROR: no item moved for %0d cycles, %0d writes outstanding",
                             stall_cycles, expected_writes.size());
                    $display("TEST FAILED");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Slow sender against a mostly stalled receiver.
        send_idle_pct = 37;
        recv_idle_pct = 87;
        queue_directed();
        queue_random(80);
        wait_drained();

        // The other way round.
        send_idle_pct = 87;
        recv_idle_pct = 37;
        queue_random(80);
        wait_drained();

        // Full rate, starting with a long receiver hold-off so the block backs up.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        queue_random(80);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d items and %0d checked memory writes over three idle profiles,",
                 items_accepted, writes_checked);
        $display("one long receiver hold-off, %0d address wraps; %0d mismatches.",
                 addr_wraps, mismatches);
        if (mismatches == 0 && expected_writes.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/i2cnsp_pkg.sv
rtl/i2cnsp_fifo.sv
rtl/i2cnsp_front.sv
rtl/i2cnsp_back.sv
rtl/i2c_nibble_sequence_packer.sv
rtl/i2cnsp_checker.sv
dv/i2c_nibble_sequence_packer_tb.sv
